// ===== rtl/core/swm_pkg.sv =====
// Shared constants, types and state encoding for the sliding window median block.
`timescale 1ns / 1ps
package swm_pkg;

  // Window and sample geometry
  localparam int WINDOW_CAPACITY = 32;
  localparam int SAMPLE_BITS     = 16;
  localparam int IDX_W           = $clog2(WINDOW_CAPACITY);
  localparam int CNT_W           = $clog2(WINDOW_CAPACITY + 1);

  // Window length after reset
  localparam logic [CNT_W-1:0] WLEN_RESET = CNT_W'(3);

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_RESULT
  } swm_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;    // sample beat taken, ring read issued
    logic cfg_wr;    // window length written, window cleared
    logic remove;    // drop the oldest sample from the sorted row
    logic insert;    // insert the new sample, write the ring
    logic load_out;  // capture median, minimum and count
  } swm_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;       // window holds window_length samples, saturated to 1..capacity
    logic out_stall;  // result register occupied and not taken
  } swm_status_t;

endpackage

// ===== rtl/core/swm_channels.sv =====
// Valid/ready channel interfaces for samples, results and configuration.
`timescale 1ns / 1ps

interface swm_sample_if;
  import swm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_result_if;
  import swm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] median_value;
  logic [SAMPLE_BITS-1:0] minimum_value;
  logic [CNT_W-1:0]       fill_count;
  modport source (output valid, output median_value, output minimum_value,
                  output fill_count, input ready);
  modport sink   (input valid, input median_value, input minimum_value,
                  input fill_count, output ready);
endinterface

interface swm_cfg_if;
  import swm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sliding_window_median_min.sv =====
// Flow: a sample beat is taken only in idle; once the window is full the oldest sample is
//   first removed from the sorted cell row, then the new one is inserted, then the result is
//   captured, waiting while the output stalls; the next beat is taken only after capture.
// Reset: window length 3, window empty; a configuration beat also empties the window.
// Ring and sorted cells are not cleared; only entries written since the last clear are read.
// Top level of the sliding window median and minimum block.
`timescale 1ns / 1ps
module sliding_window_median_min import swm_pkg::*; (
  input logic          clk,
  input logic          rst,
  swm_sample_if.sink   samples,
  swm_result_if.source results,
  swm_cfg_if.sink      cfg
);

  swm_cmd_t    cmd;
  swm_status_t status;

  // Sequencer
  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Window storage and result register
  swm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample        (samples.sample),
    .cfg_data      (cfg.data),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .median_value  (results.median_value),
    .minimum_value (results.minimum_value),
    .fill_count    (results.fill_count)
  );

endmodule

// ===== rtl/core/swm_ctrl.sv =====
// Controller state machine sequencing removal, insertion and result capture.
`timescale 1ns / 1ps
module swm_ctrl import swm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  swm_status_t status,
  output swm_cmd_t    cmd
);

  swm_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        // configuration wins over a sample beat in the same cycle
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.full ? ST_REMOVE : ST_INSERT;
        end
      end
      ST_REMOVE: begin
        cmd.remove = 1'b1;
        state_next = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!status.out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // At most one datapath operation per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.cfg_wr, cmd.remove, cmd.insert, cmd.load_out}))
    else $error("swm_ctrl: more than one command issued");

endmodule

// ===== rtl/core/swm_datapath.sv =====
// Datapath: arrival ring memory, sorted compare-and-shift cell row, result register.
`timescale 1ns / 1ps
module swm_datapath import swm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  swm_cmd_t               cmd,
  output swm_status_t            status,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [CNT_W-1:0]       cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] median_value,
  output logic [SAMPLE_BITS-1:0] minimum_value,
  output logic [CNT_W-1:0]       fill_count
);

  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(WINDOW_CAPACITY);

  logic [CNT_W-1:0]       window_length;
  logic [CNT_W-1:0]       held;
  logic [IDX_W-1:0]       oldest;
  logic [IDX_W-1:0]       wr_addr;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] old_q;
  logic [SAMPLE_BITS-1:0] ring  [WINDOW_CAPACITY];
  logic [SAMPLE_BITS-1:0] cells [WINDOW_CAPACITY];

  logic [CNT_W-1:0]           len_eff;
  logic                       full;
  logic [CNT_W-1:0]           oldest_inc;
  logic [WINDOW_CAPACITY-1:0] shift_l;
  logic [WINDOW_CAPACITY-1:0] gt;

  // Effective window length, saturated to 1..capacity
  always_comb begin
    if (window_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (window_length > CAPACITY) begin
      len_eff = CAPACITY;
    end else begin
      len_eff = window_length;
    end
  end

  assign full       = (held >= len_eff);
  assign oldest_inc = {1'b0, oldest} + CNT_W'(1);

  assign status.full      = full;
  assign status.out_stall = out_valid && !out_ready;

  // Control registers: length, count, oldest slot
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
      held          <= '0;
      oldest        <= '0;
    end else if (cmd.cfg_wr) begin
      window_length <= cfg_data;
      held          <= '0;
      oldest        <= '0;
    end else begin
      if (cmd.accept && full) begin
        oldest <= (oldest_inc == len_eff) ? '0 : oldest_inc[IDX_W-1:0];
      end
      if (cmd.remove) begin
        held <= held - CNT_W'(1);
      end else if (cmd.insert) begin
        held <= held + CNT_W'(1);
      end
    end
  end

  // Beat capture: sample, ring slot to overwrite
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= sample;
      wr_addr  <= full ? oldest : held[IDX_W-1:0];
    end
  end

  // Arrival ring: read oldest on accept, write new sample on insert
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      old_q <= ring[oldest];
    end
    if (cmd.insert) begin
      ring[wr_addr] <= sample_q;
    end
  end

  // Per-cell match and compare flags
  always_comb begin
    logic found;
    found   = 1'b0;
    shift_l = '0;
    gt      = '0;
    for (int i = 0; i < WINDOW_CAPACITY; i++) begin
      // first equal entry and everything after it shifts down one place
      found      = found | ((CNT_W'(i) < held) && (cells[i] == old_q));
      shift_l[i] = found && (CNT_W'(i + 1) < held);
      gt[i]      = (CNT_W'(i) < held) && (sample_q < cells[i]);
    end
  end

  // Sorted cell row
  for (genvar g = 0; g < WINDOW_CAPACITY; g++) begin : g_cell
    localparam logic [CNT_W-1:0] POS = CNT_W'(g);
    logic [SAMPLE_BITS-1:0] rm_val;
    logic [SAMPLE_BITS-1:0] ins_val;

    if (g < WINDOW_CAPACITY - 1) begin : g_rm
      assign rm_val = shift_l[g] ? cells[g+1] : cells[g];
    end else begin : g_rm_last
      assign rm_val = cells[g];
    end

    if (g == 0) begin : g_ins_first
      assign ins_val = (gt[g] || (held == POS)) ? sample_q : cells[g];
    end else begin : g_ins
      assign ins_val = (gt[g] || (held == POS)) ?
                       (gt[g-1] ? cells[g-1] : sample_q) : cells[g];
    end

    always_ff @(posedge clk) begin
      if (cmd.remove) begin
        cells[g] <= rm_val;
      end else if (cmd.insert) begin
        cells[g] <= ins_val;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      median_value  <= cells[IDX_W'(held >> 1)];
      minimum_value <= cells[0];
      fill_count    <= held;
    end
  end

  // Count never exceeds the window
  a_held_in_window: assert property (@(posedge clk) disable iff (rst)
    held <= len_eff)
    else $error("swm_datapath: held count above window length");

  // Oldest slot stays inside the window
  a_oldest_in_window: assert property (@(posedge clk) disable iff (rst)
    {1'b0, oldest} < len_eff)
    else $error("swm_datapath: oldest pointer outside window");

  // Sorted row keeps the minimum at the bottom
  a_min_le_median: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (minimum_value <= median_value))
    else $error("swm_datapath: minimum above median");

endmodule

// ===== tb/tb_sliding_window_median_min.sv =====
`timescale 1ns / 1ps
// Testbench for the sliding window median/minimum block: directed table, then random traffic.
module tb_sliding_window_median_min;
  import swm_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SEG_BEATS     = 193;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  // Per-phase idle percentages: none, sender only, receiver only, both
  localparam int TX_IDLE  [4] = '{0, 62, 0, 20};
  localparam int RX_STALL [4] = '{0, 0, 62, 20};

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] median;
    logic [SAMPLE_BITS-1:0] minimum;
    logic [CNT_W-1:0]       count;
  } window_stats_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [SAMPLE_BITS-1:0] value;
    logic                   typed;   // expected result given in the row
    logic [SAMPLE_BITS-1:0] median;
    logic [SAMPLE_BITS-1:0] minimum;
    logic [CNT_W-1:0]       count;
  } stim_row_t;

  // Directed table; untyped rows are checked against the window model
  localparam stim_row_t DIRECTED_ROWS [19] = '{
    // reset window of 3: extremes, sample equal to the held maximum, eviction
    '{ROW_SAMPLE, 16'h0000, 1'b1, 16'h0000, 16'h0000, 6'd1},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF, 16'h0000, 6'd2},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF, 16'h0000, 6'd3},
    '{ROW_SAMPLE, 16'h0100, 1'b1, 16'hFFFF, 16'h0100, 6'd3},
    '{ROW_SAMPLE, 16'h0100, 1'b1, 16'h0100, 16'h0100, 6'd3},
    // length zero saturates to one
    '{ROW_CFG,    16'd0,    1'b0, 16'h0000, 16'h0000, 6'd0},
    '{ROW_SAMPLE, 16'hAAAA, 1'b1, 16'hAAAA, 16'hAAAA, 6'd1},
    '{ROW_SAMPLE, 16'h5555, 1'b1, 16'h5555, 16'h5555, 6'd1},
    // all ones saturates to capacity
    '{ROW_CFG,    16'd63,   1'b0, 16'h0000, 16'h0000, 6'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000, 16'h0000, 6'd0},
    '{ROW_SAMPLE, 16'h0001, 1'b0, 16'h0000, 16'h0000, 6'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000, 16'h0000, 6'd0},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 6'd0},
    '{ROW_SAMPLE, 16'h0000, 1'b0, 16'h0000, 16'h0000, 6'd0},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 6'd0},
    // even window, duplicates
    '{ROW_CFG,    16'd2,    1'b0, 16'h0000, 16'h0000, 6'd0},
    '{ROW_SAMPLE, 16'h1234, 1'b0, 16'h0000, 16'h0000, 6'd0},
    '{ROW_SAMPLE, 16'h1234, 1'b0, 16'h0000, 16'h0000, 6'd0},
    '{ROW_SAMPLE, 16'h0FFF, 1'b0, 16'h0000, 16'h0000, 6'd0}
  };

  logic clk;
  logic rst;

  swm_sample_if samples_ch ();
  swm_result_if results_ch ();
  swm_cfg_if    cfg_ch ();

  sliding_window_median_min DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  // Window model state
  logic [CNT_W-1:0]       win_len_reg;
  logic [SAMPLE_BITS-1:0] ring_mem  [WINDOW_CAPACITY];
  logic [SAMPLE_BITS-1:0] order_mem [WINDOW_CAPACITY];
  int unsigned            oldest_idx;
  int unsigned            held_num;

  window_stats_t pending_results [$];
  window_stats_t want_stats;

  int tx_idle_pct;
  int rx_stall_pct;
  bit hold_request;
  bit hold_taken;
  int hold_left;
  logic [SAMPLE_BITS-1:0] last_sample;

  int errors;
  int results_checked;
  int samples_sent;
  int cfg_writes;
  int evictions;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // New length, empty window
  function automatic void window_restart(input logic [CNT_W-1:0] len);
    win_len_reg = len;
    oldest_idx  = 0;
    held_num    = 0;
  endfunction

  // Advance the window by one sample and return median, minimum and count
  function automatic window_stats_t window_accept(input logic [SAMPLE_BITS-1:0] s);
    int unsigned   len;
    int unsigned   slot;
    int unsigned   pos;
    int unsigned   i;
    window_stats_t r;
    len = win_len_reg;
    if (len < 1) len = 1;
    if (len > WINDOW_CAPACITY) len = WINDOW_CAPACITY;
    if (held_num >= len) begin
      // full: oldest sample leaves the ring and one equal sorted entry goes
      slot = oldest_idx % len;
      pos  = held_num - 1;
      for (i = 0; i < held_num; i++) begin
        if (order_mem[i] == ring_mem[slot]) begin
          pos = i;
          break;
        end
      end
      for (i = pos; i + 1 < held_num; i++) order_mem[i] = order_mem[i + 1];
      held_num--;
      ring_mem[slot] = s;
      oldest_idx     = (slot + 1) % len;
      evictions++;
    end else begin
      ring_mem[(oldest_idx + held_num) % len] = s;
    end
    // insert after every entry less than or equal to s
    pos = held_num;
    for (i = 0; i < held_num; i++) begin
      if (s < order_mem[i]) begin
        pos = i;
        break;
      end
    end
    for (i = held_num; i > pos; i--) order_mem[i] = order_mem[i - 1];
    order_mem[pos] = s;
    held_num++;
    r.median  = order_mem[held_num / 2];
    r.minimum = order_mem[0];
    r.count   = CNT_W'(held_num);
    return r;
  endfunction

  // Random samples: wide values, a few clustered levels, extremes, small steps
  function automatic logic [SAMPLE_BITS-1:0] draw_sample();
    logic [SAMPLE_BITS-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = SAMPLE_BITS'($urandom_range(16'hFFFF));
      4, 5, 6:    v = SAMPLE_BITS'(($urandom_range(3) + 1) * 16'h0080);
      7:          v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default:    v = last_sample + SAMPLE_BITS'($urandom_range(4)) - 16'd2;
    endcase
    last_sample = v;
    return v;
  endfunction

  // Offer one sample beat, with random gaps, and log its expected result
  task automatic offer_sample(input logic [SAMPLE_BITS-1:0] v, input bit typed,
                              input window_stats_t typed_stats);
    window_stats_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      samples_ch.valid <= 1'b0;
      @(negedge clk);
    end
    samples_ch.valid  <= 1'b1;
    samples_ch.sample <= v;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    predicted = window_accept(v);
    pending_results.push_back(typed ? typed_stats : predicted);
    samples_sent++;
  endtask

  // Stop sending and wait until every result is back and the block is quiet
  task automatic drain_window();
    @(negedge clk);
    samples_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the window length; this also empties the window
  task automatic write_window(input logic [CNT_W-1:0] len);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    window_restart(len);
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    hold_left  = 0;
    hold_taken = 1'b0;
    results_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: median %h minimum %h count %0d", $time,
                 results_ch.median_value, results_ch.minimum_value, results_ch.fill_count);
        errors++;
      end else begin
        want_stats = pending_results.pop_front();
        results_checked++;
        if (results_ch.median_value !== want_stats.median) begin
          $display("%0t: median_value expected %h actual %h", $time,
                   want_stats.median, results_ch.median_value);
          errors++;
        end
        if (results_ch.minimum_value !== want_stats.minimum) begin
          $display("%0t: minimum_value expected %h actual %h", $time,
                   want_stats.minimum, results_ch.minimum_value);
          errors++;
        end
        if (results_ch.fill_count !== want_stats.count) begin
          $display("%0t: fill_count expected %0d actual %0d", $time,
                   want_stats.count, results_ch.fill_count);
          errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence
  initial begin
    int               r;
    int               ph;
    int               seg;
    int               b;
    logic [CNT_W-1:0] seg_len [8];
    rst               <= 1'b1;
    samples_ch.valid  <= 1'b0;
    samples_ch.sample <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    hold_request      = 1'b0;
    tx_idle_pct       = 0;
    rx_stall_pct      = 0;
    last_sample       = 16'h0100;
    errors            = 0;
    results_checked   = 0;
    samples_sent      = 0;
    cfg_writes        = 0;
    evictions         = 0;
    window_restart(WLEN_RESET);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (r = 0; r < 19; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        drain_window();
        write_window(DIRECTED_ROWS[r].value[CNT_W-1:0]);
      end else begin
        offer_sample(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed,
                     window_stats_t'{DIRECTED_ROWS[r].median, DIRECTED_ROWS[r].minimum,
                                     DIRECTED_ROWS[r].count});
      end
    end

    // Random traffic: four idle phases, two window lengths each
    seg_len = '{6'd32, 6'd5, 6'd33, 6'd1, 6'd63, CNT_W'($urandom_range(63)), 6'd2,
                CNT_W'($urandom_range(63))};
    for (ph = 0; ph < 4; ph++) begin
      for (seg = 0; seg < 2; seg++) begin
        drain_window();
        tx_idle_pct  = TX_IDLE[ph];
        rx_stall_pct = RX_STALL[ph];
        write_window(seg_len[ph * 2 + seg]);
        // back up the result path while beats keep coming
        if (ph == 0 && seg == 1) hold_request = 1'b1;
        for (b = 0; b < SEG_BEATS; b++) offer_sample(draw_sample(), 1'b0, '0);
      end
    end

    drain_window();
    $display("covered %0d samples under %0d window length writes, %0d with a full window",
             samples_sent, cfg_writes, evictions);
    $display("%0d results compared, %0d mismatching fields", results_checked, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sliding_window_median_min.f =====
rtl/core/swm_pkg.sv
rtl/core/swm_channels.sv
rtl/core/swm_ctrl.sv
rtl/core/swm_datapath.sv
rtl/core/sliding_window_median_min.sv
tb/tb_sliding_window_median_min.sv
